@@ hw/rtl/biou_pkg.sv @@
// shared types and constants for the box overlap scorer
// command/status structs between controller and datapath, register indexes
// no dependencies
package biou_pkg;

  localparam int SIZE_W    = 15;  // box width and height
  localparam int RATIO_W   = 17;  // ratio, Q1.16 at the default fraction width
  localparam int AREA_W    = 2 * SIZE_W;
  localparam int UNI_W     = AREA_W + 1;
  localparam int CFG_IDX_W = 3;

  localparam logic [RATIO_W-1:0] THR_RESET = RATIO_W'(32768);  // one half

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_X      = 3'd0,
    REG_REF_Y      = 3'd1,
    REG_REF_WIDTH  = 3'd2,
    REG_REF_HEIGHT = 3'd3,
    REG_THRESHOLD  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MUL_REF = 2'd0,
    MUL_DET = 2'd1,
    MUL_INT = 2'd2
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OVL,
    ST_MUL_REF,
    ST_MUL_DET,
    ST_MUL_INT,
    ST_UNION,
    ST_DIV_INIT,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic     cap;
    logic     ovl;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     uni;
    logic     div_init;
    logic     div_step;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } sts_t;

endpackage

@@ hw/rtl/biou_ctrl.sv @@
// controller for the box overlap scorer: sequences one item through the datapath
// and owns the input stall and the output valid
// depends on biou_pkg
module biou_ctrl import biou_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MUL_REF;
    // result taken by the receiver frees the output register
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_OVL;
        end
      end
      ST_OVL: begin
        cmd.ovl   = 1'b1;
        state_nxt = ST_MUL_REF;
      end
      ST_MUL_REF: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_REF;
        state_nxt   = ST_MUL_DET;
      end
      ST_MUL_DET: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DET;
        state_nxt   = ST_MUL_INT;
      end
      ST_MUL_INT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_INT;
        state_nxt   = ST_UNION;
      end
      ST_UNION: begin
        cmd.uni   = 1'b1;
        state_nxt = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait here until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/biou_dp.sv @@
// datapath for the box overlap scorer: config registers, overlap, shared
// multiplier, restoring divider, running best and output register
// depends on biou_pkg
module biou_dp import biou_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16,
  parameter int CFG_W      = 17
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic [COORD_BITS-1:0] in_det_x,
  input  logic [COORD_BITS-1:0] in_det_y,
  input  logic [SIZE_W-1:0]     in_det_width,
  input  logic [SIZE_W-1:0]     in_det_height,
  input  logic                  in_last_box,
  output logic [RATIO_W-1:0]    out_overlap_ratio,
  output logic [RATIO_W-1:0]    out_best_ratio,
  output logic                  out_below_threshold,
  output logic                  out_run_end
);

  localparam int EXT_W = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 2;
  localparam int QW    = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(FRAC_BITS);

  // configuration
  logic signed [COORD_BITS-1:0] ref_x_r, ref_y_r;
  logic [SIZE_W-1:0]            ref_w_r, ref_h_r;
  logic [RATIO_W-1:0]           thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_x_r <= '0;
      ref_y_r <= '0;
      ref_w_r <= '0;
      ref_h_r <= '0;
      thr_r   <= THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_REF_X:      ref_x_r <= cfg_data[COORD_BITS-1:0];
        REG_REF_Y:      ref_y_r <= cfg_data[COORD_BITS-1:0];
        REG_REF_WIDTH:  ref_w_r <= cfg_data[SIZE_W-1:0];
        REG_REF_HEIGHT: ref_h_r <= cfg_data[SIZE_W-1:0];
        REG_THRESHOLD:  thr_r   <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic signed [COORD_BITS-1:0] det_x_r, det_y_r;
  logic [SIZE_W-1:0]            det_w_r, det_h_r;
  logic                         last_r;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      det_x_r <= in_det_x;
      det_y_r <= in_det_y;
      det_w_r <= in_det_width;
      det_h_r <= in_det_height;
      last_r  <= in_last_box;
    end
  end

  // overlap extent on each axis, clamped at zero
  logic signed [EXT_W-1:0] rx_lo, rx_hi, dx_lo, dx_hi, ry_lo, ry_hi, dy_lo, dy_hi;
  logic signed [EXT_W-1:0] ow, oh;
  logic [SIZE_W-1:0]       ow_r, oh_r;

  always_comb begin
    rx_lo = EXT_W'(ref_x_r);
    dx_lo = EXT_W'(det_x_r);
    ry_lo = EXT_W'(ref_y_r);
    dy_lo = EXT_W'(det_y_r);
    rx_hi = rx_lo + signed'(EXT_W'(ref_w_r));
    dx_hi = dx_lo + signed'(EXT_W'(det_w_r));
    ry_hi = ry_lo + signed'(EXT_W'(ref_h_r));
    dy_hi = dy_lo + signed'(EXT_W'(det_h_r));
    ow = ((rx_hi < dx_hi) ? rx_hi : dx_hi) - ((rx_lo > dx_lo) ? rx_lo : dx_lo);
    oh = ((ry_hi < dy_hi) ? ry_hi : dy_hi) - ((ry_lo > dy_lo) ? ry_lo : dy_lo);
  end

  always_ff @(posedge clk) begin
    if (cmd.ovl) begin
      ow_r <= ow[EXT_W-1] ? '0 : ow[SIZE_W-1:0];
      oh_r <= oh[EXT_W-1] ? '0 : oh[SIZE_W-1:0];
    end
  end

  // one shared multiplier for the two areas and the intersection
  logic [SIZE_W-1:0] mul_a, mul_b;
  logic [AREA_W-1:0] mul_p;
  logic [AREA_W-1:0] area_ref_r, area_det_r, inter_r;

  always_comb begin
    case (cmd.mul_sel)
      MUL_REF: begin mul_a = ref_w_r; mul_b = ref_h_r; end
      MUL_DET: begin mul_a = det_w_r; mul_b = det_h_r; end
      MUL_INT: begin mul_a = ow_r;    mul_b = oh_r;    end
      default: begin mul_a = ow_r;    mul_b = oh_r;    end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MUL_REF: area_ref_r <= mul_p;
        MUL_DET: area_det_r <= mul_p;
        default: inter_r    <= mul_p;
      endcase
    end
  end

  // union never goes negative since the intersection fits in either box
  logic [UNI_W-1:0] uni_r;
  logic             uni_zero_r;

  always_ff @(posedge clk) begin
    if (cmd.uni) begin
      uni_r      <= UNI_W'(area_ref_r) + UNI_W'(area_det_r) - UNI_W'(inter_r);
      uni_zero_r <= (area_ref_r == '0) && (area_det_r == '0);
    end
  end

  // restoring divider, one quotient bit a cycle; remainder stays below union
  logic [UNI_W-1:0] rem_r;
  logic [QW-1:0]    q_r;
  logic [CNT_W-1:0] cnt_r;
  logic [UNI_W:0]   init_num, step_num;
  logic             init_ge, step_ge;

  always_comb begin
    init_num = (UNI_W + 1)'(inter_r);
    init_ge  = init_num >= {1'b0, uni_r};
    step_num = {rem_r, 1'b0};
    step_ge  = step_num >= {1'b0, uni_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= init_ge ? UNI_W'(init_num - {1'b0, uni_r}) : UNI_W'(init_num);
      q_r   <= QW'(init_ge);
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= step_ge ? UNI_W'(step_num - {1'b0, uni_r}) : UNI_W'(step_num);
      q_r   <= {q_r[QW-2:0], step_ge};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign sts.div_last = (cnt_r == CNT_W'(FRAC_BITS - 1));

  // quotient to ratio width, saturating when the fraction is wide
  logic [RATIO_W-1:0] ratio_q, ratio;

  if (QW <= RATIO_W) begin : g_ratio_fit
    assign ratio_q = RATIO_W'(q_r);
  end else begin : g_ratio_sat
    assign ratio_q = (|q_r[QW-1:RATIO_W]) ? '1 : q_r[RATIO_W-1:0];
  end

  assign ratio = uni_zero_r ? '0 : ratio_q;

  // running best and output register
  logic [RATIO_W-1:0] best_r, best_new;

  assign best_new = (ratio > best_r) ? ratio : best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
    end else if (cmd.load_out) begin
      best_r <= last_r ? '0 : best_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_overlap_ratio   <= ratio;
      out_best_ratio      <= best_new;
      out_below_threshold <= last_r && (best_new < thr_r);
      out_run_end         <= last_r;
    end
  end

endmodule

@@ hw/rtl/box_iou_max_threshold.sv @@
// Box overlap scorer with a per-run best-match check.
// Input channel (in_valid / in_stall) carries one detection box per item;
// result channel (out_valid / out_stall) returns one item per detection with
// the intersection-over-union against the configured reference box, the best
// ratio of the run so far, and on the last item of a run whether that best
// lies under the threshold. The best is cleared after the last item.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
// must write it only while the block is idle, which the block does not enforce.
// Each item goes through capture, overlap, three passes through one shared
// multiplier, union, then FRAC_BITS + 1 steps of a bit-serial restoring
// divider and the output load.
// in_stall is high while an item is in work.
// The result sits in an output register; a stalled receiver holds it, and
// the next item is accepted and worked on meanwhile, waiting at the end only
// if the previous result has still not been taken.
// Reset (synchronous, rst_n low) clears the run's best ratio, sets the
// reference box to zero and the threshold to one half.
// depends on biou_pkg, biou_ctrl, biou_dp
module box_iou_max_threshold import biou_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16,
  localparam int CFG_W = (COORD_BITS > RATIO_W) ? COORD_BITS : RATIO_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_det_x,
  input  logic [COORD_BITS-1:0] in_det_y,
  input  logic [SIZE_W-1:0]     in_det_width,
  input  logic [SIZE_W-1:0]     in_det_height,
  input  logic                  in_last_box,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [RATIO_W-1:0]    out_overlap_ratio,
  output logic [RATIO_W-1:0]    out_best_ratio,
  output logic                  out_below_threshold,
  output logic                  out_run_end,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  cmd_t cmd;
  sts_t sts;

  biou_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  biou_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .CFG_W      (CFG_W)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_det_x            (in_det_x),
    .in_det_y            (in_det_y),
    .in_det_width        (in_det_width),
    .in_det_height       (in_det_height),
    .in_last_box         (in_last_box),
    .out_overlap_ratio   (out_overlap_ratio),
    .out_best_ratio      (out_best_ratio),
    .out_below_threshold (out_below_threshold),
    .out_run_end         (out_run_end)
  );

endmodule

@@ bench/tb_box_iou_max_threshold.sv @@
// testbench for box_iou_max_threshold: streams detection boxes against a configured reference
// box and checks each result item against an overlap predictor kept in the bench
// depends on biou_pkg and the box_iou_max_threshold rtl

localparam int COORD_W   = 16;
localparam int FRAC_W    = 16;
localparam int CFG_W     = (COORD_W > biou_pkg::RATIO_W) ? COORD_W : biou_pkg::RATIO_W;
localparam longint RATIO_MAX = (64'd1 << biou_pkg::RATIO_W) - 1;

typedef struct packed {
  logic [biou_pkg::RATIO_W-1:0] overlap_ratio;
  logic [biou_pkg::RATIO_W-1:0] best_ratio;
  logic                         below_threshold;
  logic                         run_end;
} iou_result_t;

class iou_scoreboard;
  logic signed [COORD_W-1:0]         ref_x;
  logic signed [COORD_W-1:0]         ref_y;
  logic [biou_pkg::SIZE_W-1:0]       ref_w;
  logic [biou_pkg::SIZE_W-1:0]       ref_h;
  logic [biou_pkg::RATIO_W-1:0]      threshold;
  logic [biou_pkg::RATIO_W-1:0]      run_best;
  iou_result_t                       expected_scores[$];
  int                                mismatches;

  function new();
    ref_x      = '0;
    ref_y      = '0;
    ref_w      = '0;
    ref_h      = '0;
    threshold  = biou_pkg::THR_RESET;
    run_best   = '0;
    mismatches = 0;
  endfunction

  function void write_reg(biou_pkg::cfg_reg_t idx, logic [CFG_W-1:0] data);
    case (idx)
      biou_pkg::REG_REF_X:      ref_x = data[COORD_W-1:0];
      biou_pkg::REG_REF_Y:      ref_y = data[COORD_W-1:0];
      biou_pkg::REG_REF_WIDTH:  ref_w = data[biou_pkg::SIZE_W-1:0];
      biou_pkg::REG_REF_HEIGHT: ref_h = data[biou_pkg::SIZE_W-1:0];
      biou_pkg::REG_THRESHOLD:  threshold = data[biou_pkg::RATIO_W-1:0];
      default: ;
    endcase
  endfunction

  // intersection over union against the reference box, plus the run's best
  function iou_result_t predict_overlap(logic signed [COORD_W-1:0] det_x,
                                        logic signed [COORD_W-1:0] det_y,
                                        logic [biou_pkg::SIZE_W-1:0] det_w,
                                        logic [biou_pkg::SIZE_W-1:0] det_h,
                                        logic last);
    longint rx, ry, rw, rh, dx, dy, dw, dh;
    longint lo_x, lo_y, ow, oh, inter, uni, ratio;
    iou_result_t res;
    rx = ref_x;
    ry = ref_y;
    rw = ref_w;
    rh = ref_h;
    dx = det_x;
    dy = det_y;
    dw = det_w;
    dh = det_h;
    lo_x = (rx > dx) ? rx : dx;
    lo_y = (ry > dy) ? ry : dy;
    // right and bottom edges are exact, no wrap
    ow = ((rx + rw < dx + dw) ? rx + rw : dx + dw) - lo_x;
    oh = ((ry + rh < dy + dh) ? ry + rh : dy + dh) - lo_y;
    inter = (ow < 0 || oh < 0) ? 0 : ow * oh;
    uni = rw * rh + dw * dh - inter;
    ratio = (uni == 0) ? 0 : (inter <<< FRAC_W) / uni;
    if (ratio > RATIO_MAX) ratio = RATIO_MAX;
    if (ratio > longint'(run_best)) run_best = ratio[biou_pkg::RATIO_W-1:0];
    res.overlap_ratio   = ratio[biou_pkg::RATIO_W-1:0];
    res.best_ratio      = run_best;
    res.below_threshold = last && (run_best < threshold);
    res.run_end         = last;
    if (last) run_best = '0;
    return res;
  endfunction

  function void note_detection(logic signed [COORD_W-1:0] det_x,
                               logic signed [COORD_W-1:0] det_y,
                               logic [biou_pkg::SIZE_W-1:0] det_w,
                               logic [biou_pkg::SIZE_W-1:0] det_h,
                               logic last);
    expected_scores.push_back(predict_overlap(det_x, det_y, det_w, det_h, last));
  endfunction

  function void compare_field(string name, logic [biou_pkg::RATIO_W-1:0] want,
                              logic [biou_pkg::RATIO_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_result(iou_result_t got);
    iou_result_t want;
    if (expected_scores.size() == 0) begin
      $error("result item arrived with no detection outstanding");
      mismatches++;
      return;
    end
    want = expected_scores.pop_front();
    compare_field("overlap_ratio", want.overlap_ratio, got.overlap_ratio);
    compare_field("best_ratio", want.best_ratio, got.best_ratio);
    compare_field("below_threshold", (biou_pkg::RATIO_W)'(want.below_threshold),
                  (biou_pkg::RATIO_W)'(got.below_threshold));
    compare_field("run_end", (biou_pkg::RATIO_W)'(want.run_end),
                  (biou_pkg::RATIO_W)'(got.run_end));
  endfunction

  function int pending();
    return expected_scores.size();
  endfunction
endclass

module tb_box_iou_max_threshold;
  timeunit 1ns;
  timeprecision 1ps;
  import biou_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_HOLD} rx_mode_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [COORD_W-1:0]     in_det_x;
  logic [COORD_W-1:0]     in_det_y;
  logic [SIZE_W-1:0]      in_det_width;
  logic [SIZE_W-1:0]      in_det_height;
  logic                   in_last_box;
  logic                   out_valid;
  logic                   out_stall;
  logic [RATIO_W-1:0]     out_overlap_ratio;
  logic [RATIO_W-1:0]     out_best_ratio;
  logic                   out_below_threshold;
  logic                   out_run_end;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  iou_scoreboard          scores = new();

  // reference box as last written, used to aim the random boxes
  logic signed [COORD_W-1:0] cur_x, cur_y;
  logic [SIZE_W-1:0]         cur_w, cur_h;
  int                        burst_left;

  box_iou_max_threshold i_dut (.*);

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // accepted items on both channels and register writes feed the scoreboard
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      scores.note_detection(in_det_x, in_det_y, in_det_width, in_det_height, in_last_box);
    if (rst_n && out_valid && !out_stall)
      scores.check_result(iou_result_t'{out_overlap_ratio, out_best_ratio,
                                        out_below_threshold, out_run_end});
    if (rst_n && cfg_we)
      scores.write_reg(cfg_reg_t'(cfg_index), cfg_data);
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver stall pattern, independent of the sender
  rx_mode_t rx_mode = RX_FREE;
  int       rx_left = 0;
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 12) : $urandom_range(1, 60);
    end
    rx_left--;
    case (rx_mode)
      RX_FREE:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:  out_stall <= 1'b1;
    endcase
  end

  task automatic send_box(input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
                          input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                          input logic last);
    in_valid      <= 1'b1;
    in_det_x      <= x;
    in_det_y      <= y;
    in_det_width  <= w;
    in_det_height <= h;
    in_last_box   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(0, 12);
    end
  endtask

  // hold the sender off until every result item has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (scores.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic set_reference(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                               input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                               input logic [RATIO_W-1:0] thr);
    cur_x = x;
    cur_y = y;
    cur_w = w;
    cur_h = h;
    write_cfg(REG_REF_X, CFG_W'(x));
    write_cfg(REG_REF_Y, CFG_W'(y));
    write_cfg(REG_REF_WIDTH, CFG_W'(w));
    write_cfg(REG_REF_HEIGHT, CFG_W'(h));
    write_cfg(REG_THRESHOLD, CFG_W'(thr));
    cfg_we <= 1'b0;
  endtask

  function automatic int jitter(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [SIZE_W-1:0] clamp_size(int v);
    if (v < 0) return '0;
    if (v > 32767) return '1;
    return SIZE_W'(v);
  endfunction

  function automatic logic [COORD_W-1:0] edge_coord();
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return '0;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] edge_size();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return SIZE_W'(1);
      default: return SIZE_W'($urandom);
    endcase
  endfunction

  // mostly boxes near the reference so the ratios spread over the whole range
  task automatic send_random_box();
    int                        span, pick;
    logic signed [COORD_W-1:0] x, y;
    logic [SIZE_W-1:0]         w, h;
    logic                      last;
    span = int'((cur_w > cur_h) ? cur_w : cur_h) / 4 + 2;
    pick = $urandom_range(0, 99);
    last = ($urandom_range(0, 6) == 0);
    if (pick < 55) begin
      x = COORD_W'(int'(cur_x) + jitter(span));
      y = COORD_W'(int'(cur_y) + jitter(span));
      w = clamp_size(int'(cur_w) + jitter(span));
      h = clamp_size(int'(cur_h) + jitter(span));
    end else if (pick < 65) begin
      x = cur_x;
      y = cur_y;
      w = cur_w;
      h = cur_h;
    end else if (pick < 85) begin
      x = COORD_W'($urandom);
      y = COORD_W'($urandom);
      w = SIZE_W'($urandom);
      h = SIZE_W'($urandom);
    end else if (pick < 95) begin
      x = edge_coord();
      y = edge_coord();
      w = edge_size();
      h = edge_size();
    end else begin
      // degenerate box: no area
      x = COORD_W'(int'(cur_x) + jitter(span));
      y = COORD_W'(int'(cur_y) + jitter(span));
      w = $urandom_range(0, 1) ? '0 : SIZE_W'($urandom);
      h = (w == 0) ? SIZE_W'($urandom_range(0, 3)) : '0;
    end
    send_box(x, y, w, h, last);
  endtask

  initial begin
    int phase, n;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_det_x      <= '0;
    in_det_y      <= '0;
    in_det_width  <= '0;
    in_det_height <= '0;
    in_last_box   <= 1'b0;
    out_stall     <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_REF_X;
    cfg_data      <= '0;
    cur_x         = '0;
    cur_y         = '0;
    cur_w         = '0;
    cur_h         = '0;
    burst_left    = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: empty reference box, threshold one half
    send_box(0, 0, 0, 0, 1'b0);
    send_box(-5, -5, 10, 10, 1'b0);
    send_box(0, 0, 0, 0, 1'b1);
    wait_idle();

    set_reference(100, -50, 200, 100, 32768);
    send_box(100, -50, 200, 100, 1'b0);        // identical box
    send_box(-32768, -32768, 10, 10, 1'b0);    // far away
    send_box(300, -50, 50, 100, 1'b0);         // touching edge, zero overlap width
    send_box(50, -100, 100, 100, 1'b1);
    send_box(200, -50, 200, 100, 1'b0);
    send_box(150, 0, 0, 0, 1'b1);              // empty box inside the reference
    send_box(-32768, -32768, 32767, 32767, 1'b0);
    send_box(32767, 32767, 32767, 32767, 1'b0);
    send_box(0, -32768, 32767, 32767, 1'b0);
    send_box(-1, -1, 32767, 32767, 1'b1);
    wait_idle();

    // widest reference at the corner; zero threshold never flags
    set_reference(-32768, 32767, 32767, 32767, 0);
    send_box(-32768, 32767, 32767, 32767, 1'b0);
    send_box(32767, 32767, 32767, 32767, 1'b1);
    send_box(0, 0, 0, 0, 1'b1);
    wait_idle();

    set_reference(0, 0, 1, 1, 65536);
    send_box(0, 0, 1, 1, 1'b1);
    send_box(0, 0, 2, 2, 1'b1);
    send_box(0, 0, 32767, 1, 1'b0);
    send_box(-32768, 0, 32767, 32767, 1'b1);

    for (phase = 0; phase < 5; phase++) begin
      wait_idle();
      case (phase)
        0: set_reference(COORD_W'(int'($urandom_range(0, 2000)) - 1000),
                         COORD_W'(int'($urandom_range(0, 2000)) - 1000),
                         SIZE_W'($urandom_range(1, 300)),
                         SIZE_W'($urandom_range(1, 300)),
                         RATIO_W'($urandom_range(0, 65536)));
        1: set_reference(COORD_W'($urandom), COORD_W'($urandom), SIZE_W'($urandom),
                         SIZE_W'($urandom), 65536);
        2: set_reference(-32768, -32768, 32767, 32767, RATIO_W'($urandom_range(0, 65536)));
        3: set_reference(32767, 32767, 0, 7, 0);
        default: set_reference(COORD_W'(int'($urandom_range(0, 200)) - 100),
                               COORD_W'(int'($urandom_range(0, 200)) - 100),
                               SIZE_W'($urandom_range(1, 16)),
                               SIZE_W'($urandom_range(1, 16)),
                               RATIO_W'($urandom_range(0, 65536)));
      endcase
      for (n = 0; n < 200; n++) begin
        send_random_box();
        if (phase == 1 && n == 100) wait_idle();
      end
    end

    wait_idle();
    repeat (30) @(posedge clk);
    if (scores.mismatches == 0 && scores.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ box_iou_max_threshold.f @@
hw/rtl/biou_pkg.sv
hw/rtl/biou_ctrl.sv
hw/rtl/biou_dp.sv
hw/rtl/box_iou_max_threshold.sv
bench/tb_box_iou_max_threshold.sv
